>>> src/esret_pkg.sv
// ----------------------------------------------------------------------------
// esret_pkg
// Types and constants shared by the ELLPACK sparse row entry table.
// ----------------------------------------------------------------------------
package esret_pkg;

    localparam int TAG_W      = 8;
    localparam int VAL_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [VAL_W-1:0] Q_ONE = 32'h0001_0000;

    // operation codes
    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_ADD    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_SCALE  = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;
    localparam logic [2:0] OP_UNIT   = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOSLOT = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = 2'd2;

    typedef struct packed {
        logic [2:0]              op;
        logic [7:0]              row;
        logic [7:0]              col;
        logic signed [VAL_W-1:0] operand;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [1:0]              status;
        logic [2:0]              slot_used;
    } t_out;

endpackage

>>> src/esret_ram.sv
// ----------------------------------------------------------------------------
// esret_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module esret_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/ell_sparse_row_entry_table.sv
// ----------------------------------------------------------------------------
// ell_sparse_row_entry_table
// Sparse matrix store in ELLPACK form with a slot-serial lookup sequencer.
// ----------------------------------------------------------------------------
// Each row owns MAX_SLOTS slots; a row word (occupied bits and column tags) sits
// in one RAM and the Q16.16 values in another. One operation beat gives one
// result beat. A lookup compares one slot per cycle with a single tag
// comparator; scale_entry registers its 32x32 product before rounding.
// clear_all sweeps the row RAM one row a cycle, and the same sweep runs after
// reset, during which no item is taken. The next item may be taken while a
// result waits on the output register.
// ----------------------------------------------------------------------------
module ell_sparse_row_entry_table
    import esret_pkg::*;
#(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_COLS  = 256,
    parameter int MAX_SLOTS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out
);

    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int NSW    = $clog2(MAX_SLOTS + 1);
    localparam int VAW    = RW + SW;
    localparam int VDEPTH = MAX_ROWS * (2 ** SW);
    localparam int WW     = MAX_SLOTS * (TAG_W + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_VRD   = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;
    localparam logic [2:0] S_SCALE = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_CLEAR = 3'd7;

    typedef struct packed {
        logic [MAX_SLOTS-1:0][TAG_W-1:0] tag;
        logic [MAX_SLOTS-1:0]            occ;
    } t_row_word;

    logic [2:0]              r_state, n_state;
    logic [8:0]              r_rows, r_cols;
    logic [3:0]              r_slots;
    t_in                     r_in;
    t_row_word               r_word;
    logic [NSW-1:0]          r_idx;
    logic [SW-1:0]           r_slot, r_free;
    logic                    r_have_free, r_matched;
    logic signed [63:0]      r_prod;
    t_out                    r_res, r_out;
    logic                    r_out_valid;
    logic [RW-1:0]           r_clr_row;
    logic                    r_clr_item;

    logic                    row_we, val_we;
    logic [RW-1:0]           row_waddr, row_raddr, row_a;
    logic [WW-1:0]           row_wdata, row_rdata;
    logic [VAW-1:0]          val_waddr, val_raddr;
    logic [VAL_W-1:0]        val_wdata, val_rdata;

    t_row_word               rd_word, unit_word, upd_word;
    logic [NSW-1:0]          ns;
    logic                    row_oob, col_oob, diag_oob, skip_zero, fail;
    logic                    cur_occ, cur_hit, scan_end, out_free;
    logic [TAG_W-1:0]        cur_tag;
    logic signed [VAL_W-1:0] old_v, add_v, scale_v;
    logic signed [VAL_W:0]   sum33;
    logic signed [63:0]      rnd, qv;

    esret_ram #(.WIDTH(WW), .DEPTH(MAX_ROWS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    esret_ram #(.WIDTH(VAL_W), .DEPTH(VDEPTH)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    assign row_a     = RW'(r_in.row);
    assign ns        = (32'(r_slots) > MAX_SLOTS) ? NSW'(MAX_SLOTS) : NSW'(r_slots);
    assign rd_word   = t_row_word'(row_rdata);
    assign row_oob   = ({1'b0, r_in.row} >= r_rows) || (32'(r_in.row) >= MAX_ROWS);
    assign col_oob   = ({1'b0, r_in.col} >= r_cols) || (32'(r_in.col) >= MAX_COLS);
    assign diag_oob  = ({1'b0, r_in.row} >= r_cols) || (32'(r_in.row) >= MAX_COLS);
    assign skip_zero = (r_in.op == OP_SET || r_in.op == OP_ADD) && (r_in.operand == '0);
    assign fail      = !r_matched && !r_have_free;
    assign out_free  = !r_out_valid || i_out_ready;

    // slot scan: one tag compare per cycle
    assign cur_occ  = r_word.occ[r_idx[SW-1:0]];
    assign cur_tag  = r_word.tag[r_idx[SW-1:0]];
    assign scan_end = (r_idx >= ns);
    assign cur_hit  = !scan_end && cur_occ && (cur_tag == r_in.col);

    // arithmetic
    assign old_v = r_matched ? $signed(val_rdata) : '0;
    assign sum33 = {old_v[VAL_W-1], old_v} + {r_in.operand[VAL_W-1], r_in.operand};
    assign add_v = (sum33[VAL_W] != sum33[VAL_W-1])
                 ? (sum33[VAL_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                 : sum33[VAL_W-1:0];
    assign rnd   = r_prod + 64'sd32768;
    assign qv    = rnd >>> 16;
    assign scale_v = (qv > 64'sd2147483647)  ? 32'sh7FFF_FFFF :
                     (qv < -64'sd2147483648) ? 32'sh8000_0000 : qv[VAL_W-1:0];

    always_comb begin
        unit_word = rd_word;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (i == 0) begin
                unit_word.occ[i] = 1'b1;
            end else if (NSW'(i) < ns) begin
                unit_word.occ[i] = 1'b0;
            end
        end
        unit_word.tag[0] = r_in.row;
    end

    always_comb begin
        upd_word              = r_word;
        upd_word.occ[r_slot]  = (r_in.op != OP_REMOVE);
        if (r_in.op != OP_REMOVE) begin
            upd_word.tag[r_slot] = r_in.col;
        end
    end

    always_comb begin
        n_state   = r_state;
        row_we    = 1'b0;
        row_waddr = row_a;
        row_wdata = upd_word;
        row_raddr = (r_state == S_IDLE) ? RW'(i_in.row) : row_a;
        val_we    = 1'b0;
        val_waddr = {row_a, r_slot};
        val_wdata = r_in.operand;
        val_raddr = {row_a, r_slot};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                case (r_in.op)
                    OP_CLEAR: begin
                        n_state = S_CLEAR;
                    end
                    OP_UNIT: begin
                        if (!row_oob && !diag_oob && ns != '0) begin
                            row_we    = 1'b1;
                            row_wdata = unit_word;
                            val_we    = 1'b1;
                            val_waddr = {row_a, SW'(0)};
                            val_wdata = Q_ONE;
                        end
                        n_state = S_FIN;
                    end
                    OP_GET, OP_SET, OP_ADD, OP_REMOVE, OP_SCALE: begin
                        if (row_oob || col_oob || skip_zero) begin
                            n_state = S_FIN;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_SCAN: begin
                if (scan_end || cur_hit) begin
                    n_state = S_VRD;
                end
            end
            S_VRD: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_FIN;
                if (!fail) begin
                    case (r_in.op)
                        OP_SET: begin
                            row_we = 1'b1;
                            val_we = 1'b1;
                        end
                        OP_ADD: begin
                            row_we    = 1'b1;
                            val_we    = 1'b1;
                            val_wdata = add_v;
                        end
                        OP_REMOVE: begin
                            row_we = 1'b1;
                        end
                        OP_SCALE: begin
                            n_state = S_SCALE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCALE: begin
                row_we    = 1'b1;
                val_we    = 1'b1;
                val_wdata = scale_v;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                row_we    = 1'b1;
                row_waddr = r_clr_row;
                row_wdata = '0;
                if (r_clr_row == RW'(MAX_ROWS - 1)) begin
                    n_state = r_clr_item ? S_FIN : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_row   <= '0;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rows      <= 9'd256;
            r_cols      <= 9'd256;
            r_slots     <= 4'd8;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROWS:  r_rows  <= i_cfg_data;
                    CFG_COLS:  r_cols  <= i_cfg_data;
                    CFG_SLOTS: r_slots <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_CHECK && r_in.op == OP_CLEAR) begin
                r_clr_row  <= '0;
                r_clr_item <= 1'b1;
            end else if (r_state == S_CLEAR) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_in        <= i_in;
                    r_res       <= '0;
                    r_matched   <= 1'b0;
                    r_have_free <= 1'b0;
                    r_idx       <= '0;
                    r_slot      <= '0;
                end
            end
            S_CHECK: begin
                r_word <= rd_word;
                if (r_in.op == OP_UNIT) begin
                    if (row_oob || diag_oob) begin
                        r_res.status <= ST_RANGE;
                    end else if (ns == '0) begin
                        r_res.status <= ST_NOSLOT;
                    end
                end else if (r_in.op <= OP_SCALE && (row_oob || col_oob)) begin
                    r_res.status <= ST_RANGE;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    r_slot <= r_free;
                end else begin
                    r_idx <= r_idx + 1'b1;
                    if (!cur_occ) begin
                        r_free      <= r_idx[SW-1:0];
                        r_have_free <= 1'b1;
                    end else if (cur_hit) begin
                        r_matched <= 1'b1;
                        r_slot    <= r_idx[SW-1:0];
                    end
                end
            end
            S_EXEC: begin
                if (r_in.op == OP_GET) begin
                    if (r_matched) begin
                        r_res.read_value <= val_rdata;
                        r_res.slot_used  <= 3'(r_slot);
                    end
                end else if (fail) begin
                    r_res.status <= ST_NOSLOT;
                end else begin
                    r_res.slot_used <= 3'(r_slot);
                    r_prod          <= old_v * r_in.operand;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> sim/ell_sparse_row_entry_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ell_sparse_row_entry_table_tb
// Checks every result beat of the ELLPACK entry table against a local model.
// ----------------------------------------------------------------------------
// A directed part covers each operation, saturation and rounding extremes,
// full rows, range errors, zero and oversized registers and the undefined op.
// Random phases then run on several table shapes, hitting a few hot rows and
// columns so that rows fill up, with random gaps on both handshakes.
// ----------------------------------------------------------------------------
module ell_sparse_row_entry_table_tb;
    import esret_pkg::*;

    localparam int MAX_ROWS  = 256;
    localparam int MAX_COLS  = 256;
    localparam int MAX_SLOTS = 8;
    localparam int IDLE_WAIT = 300;
    localparam logic [2:0] OP_UNDEF = 3'd7;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out;

    ell_sparse_row_entry_table #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #10 i_clk = ~i_clk;

    // table model
    logic signed [31:0] entry_val [0:MAX_ROWS*MAX_SLOTS-1];
    logic [7:0]         entry_tag [0:MAX_ROWS*MAX_SLOTS-1];
    bit                 entry_occ [0:MAX_ROWS*MAX_SLOTS-1];
    logic [8:0]         rows_in_use;
    logic [8:0]         cols_in_use;
    logic [3:0]         slots_in_use;

    t_out pending_results[$];
    int   err_count   = 0;
    int   in_gap      = 0;
    int   in_max_gap  = 8;
    int   out_max_gap = 8;

    function automatic logic signed [31:0] sat32(longint v);
        if (v > SAT_HI) return 32'sh7FFF_FFFF;
        if (v < SAT_LO) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Q16.16 product, round half up
    function automatic logic signed [31:0] q_mul(logic signed [31:0] a,
                                                 logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat32((p + 64'sd32768) >>> 16);
    endfunction

    // matching slot, else highest free slot, else -1
    function automatic int find_slot(int unsigned base, int unsigned ns,
                                     logic [7:0] col, output bit hit);
        int fr;
        fr  = -1;
        hit = 1'b0;
        for (int i = 0; i < ns; i++) begin
            if (!hit) begin
                if (!entry_occ[base+i]) begin
                    fr = i;
                end else if (entry_tag[base+i] == col) begin
                    hit = 1'b1;
                    fr  = i;
                end
            end
        end
        return fr;
    endfunction

    function automatic t_out table_op(t_in beat);
        t_out               res;
        int unsigned        nr, nc, ns, base;
        int                 s;
        bit                 hit;
        logic signed [31:0] prev;
        res  = '0;
        nr   = (rows_in_use > MAX_ROWS) ? MAX_ROWS : rows_in_use;
        nc   = (cols_in_use > MAX_COLS) ? MAX_COLS : cols_in_use;
        ns   = (slots_in_use > MAX_SLOTS) ? MAX_SLOTS : slots_in_use;
        base = beat.row * MAX_SLOTS;
        case (beat.op)
            OP_CLEAR: begin
                for (int i = 0; i < MAX_ROWS*MAX_SLOTS; i++) begin
                    entry_val[i] = '0;
                    entry_occ[i] = 1'b0;
                end
            end
            OP_UNIT: begin
                if (beat.row >= nr || beat.row >= nc) begin
                    res.status = ST_RANGE;
                end else if (ns == 0) begin
                    res.status = ST_NOSLOT;
                end else begin
                    for (int i = 1; i < ns; i++) begin
                        entry_val[base+i] = '0;
                        entry_occ[base+i] = 1'b0;
                    end
                    entry_val[base] = Q_ONE;
                    entry_tag[base] = beat.row;
                    entry_occ[base] = 1'b1;
                end
            end
            OP_GET, OP_SET, OP_ADD, OP_REMOVE, OP_SCALE: begin
                if (beat.row >= nr || beat.col >= nc) begin
                    res.status = ST_RANGE;
                end else if (beat.op == OP_GET) begin
                    s = find_slot(base, ns, beat.col, hit);
                    if (hit) begin
                        res.read_value = entry_val[base+s];
                        res.slot_used  = s[2:0];
                    end
                end else if ((beat.op == OP_SET || beat.op == OP_ADD) &&
                             beat.operand == 0) begin
                    // zero operand: no change
                end else begin
                    s = find_slot(base, ns, beat.col, hit);
                    if (s < 0) begin
                        res.status = ST_NOSLOT;
                    end else begin
                        prev          = hit ? entry_val[base+s] : 32'sd0;
                        res.slot_used = s[2:0];
                        if (beat.op == OP_REMOVE) begin
                            entry_val[base+s] = '0;
                            entry_occ[base+s] = 1'b0;
                        end else begin
                            case (beat.op)
                                OP_SET: entry_val[base+s] = beat.operand;
                                OP_ADD: entry_val[base+s] = sat32(longint'(prev) +
                                            longint'($signed(beat.operand)));
                                default: entry_val[base+s] = q_mul(prev,
                                            $signed(beat.operand));
                            endcase
                            entry_tag[base+s] = beat.col;
                            entry_occ[base+s] = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic do_op(logic [2:0] op, logic [7:0] row, logic [7:0] col,
                         logic [31:0] operand);
        t_in beat;
        beat.op      = op;
        beat.row     = row;
        beat.col     = col;
        beat.operand = operand;
        repeat (in_gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(table_op(beat));
        in_gap = $urandom_range(0, in_max_gap);
        if (in_gap != 0) i_in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        if (in_gap == 0) i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_shape(logic [8:0] rows, logic [8:0] cols, logic [3:0] slots);
        wait_idle();
        repeat (IDLE_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROWS;
        i_cfg_data  <= rows;
        @(posedge i_clk);
        i_cfg_index <= CFG_COLS;
        i_cfg_data  <= cols;
        @(posedge i_clk);
        i_cfg_index <= CFG_SLOTS;
        i_cfg_data  <= {5'd0, slots};
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        rows_in_use  = rows;
        cols_in_use  = cols;
        slots_in_use = slots;
    endtask

    task automatic test_basic_ops();
        do_op(OP_GET,    8'd0,   8'd0,   32'h0);
        do_op(OP_SET,    8'd0,   8'd5,   32'h7FFF_FFFF);
        do_op(OP_ADD,    8'd0,   8'd5,   32'h1);
        do_op(OP_ADD,    8'd0,   8'd6,   32'h8000_0000);
        do_op(OP_ADD,    8'd0,   8'd6,   32'hFFFF_FFFF);
        do_op(OP_SCALE,  8'd0,   8'd5,   32'h8000_0000);
        do_op(OP_GET,    8'd0,   8'd5,   32'h0);
        do_op(OP_SCALE,  8'd0,   8'd9,   32'h5);
        do_op(OP_SET,    8'd0,   8'd5,   32'h0);
        do_op(OP_ADD,    8'd0,   8'd5,   32'h0);
        do_op(OP_REMOVE, 8'd0,   8'd5,   32'h0);
        do_op(OP_REMOVE, 8'd0,   8'd200, 32'h0);
        do_op(OP_UNIT,   8'd255, 8'd0,   32'h0);
        do_op(OP_UNDEF,  8'd255, 8'd255, 32'hFFFF_FFFF);
        do_op(OP_CLEAR,  8'd170, 8'd85,  32'hA5A5_5A5A);
        do_op(OP_GET,    8'd255, 8'd255, 32'h0);
    endtask

    task automatic test_rounding_full_row();
        set_shape(9'd256, 9'd256, 4'd1);
        do_op(OP_SET,   8'd3, 8'd1, 32'hFFFF_FFFF);
        do_op(OP_SCALE, 8'd3, 8'd1, 32'h0000_8000);
        do_op(OP_SET,   8'd3, 8'd1, 32'h1);
        do_op(OP_SCALE, 8'd3, 8'd1, 32'h0000_8000);
        do_op(OP_SET,   8'd3, 8'd2, 32'h7);
    endtask

    task automatic test_range_and_regs();
        set_shape(9'd4, 9'd200, 4'd8);
        do_op(OP_GET, 8'd4, 8'd0,   32'h0);
        do_op(OP_SET, 8'd0, 8'd200, 32'h5);
        set_shape(9'd200, 9'd3, 4'd8);
        do_op(OP_UNIT, 8'd5, 8'd0, 32'h0);
        set_shape(9'd0, 9'd0, 4'd0);
        do_op(OP_GET, 8'd0, 8'd0, 32'h0);
        set_shape(9'd256, 9'd256, 4'd0);
        do_op(OP_UNIT, 8'd1, 8'd0, 32'h0);
        do_op(OP_SET,  8'd0, 8'd0, 32'h1);
        set_shape(9'd511, 9'd511, 4'd15);
        do_op(OP_GET, 8'd3, 8'd1, 32'h0);
    endtask

    task automatic test_random_traffic();
        logic [8:0]  r, c;
        logic [3:0]  s;
        logic [2:0]  op;
        logic [7:0]  row, col;
        logic [31:0] operand;
        int          nr, nc, hr, hc, rb, cb, k;
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin r = 9'd256; c = 9'd256; s = 4'd8;  end
                1: begin r = 9'd16;  c = 9'd16;  s = 4'd8;  end
                2: begin r = 9'd4;   c = 9'd24;  s = 4'd8;  end
                3: begin r = 9'd1;   c = 9'd1;   s = 4'd1;  end
                4: begin r = 9'd511; c = 9'd511; s = 4'd15; end
                5: begin r = 9'd256; c = 9'd256; s = 4'd3;  end
                6: begin r = 9'd100; c = 9'd300; s = 4'd5;  end
                default: begin
                    r = 9'($urandom_range(1, 511));
                    c = 9'($urandom_range(1, 511));
                    s = 4'($urandom_range(1, 15));
                end
            endcase
            set_shape(r, c, s);
            in_max_gap  = (ph & 1) ? 0 : 8;
            out_max_gap = (ph & 2) ? 0 : 8;
            nr = (r > MAX_ROWS) ? MAX_ROWS : r;
            nc = (c > MAX_COLS) ? MAX_COLS : c;
            hr = (nr < 4) ? nr : 4;
            hc = (nc < 12) ? nc : 12;
            rb = $urandom_range(0, nr - hr);
            cb = $urandom_range(0, nc - hc);
            repeat (150) begin
                k = $urandom_range(0, 99);
                if (k < 22)      op = OP_GET;
                else if (k < 42) op = OP_SET;
                else if (k < 56) op = OP_ADD;
                else if (k < 68) op = OP_REMOVE;
                else if (k < 80) op = OP_SCALE;
                else if (k < 88) op = OP_UNIT;
                else if (k < 90) op = OP_CLEAR;
                else if (k < 92) op = OP_UNDEF;
                else             op = OP_SET;
                row = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                     : rb + $urandom_range(0, hr - 1));
                col = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                     : cb + $urandom_range(0, hc - 1));
                k = $urandom_range(0, 15);
                if (k < 2) begin
                    operand = 32'h0;
                end else if (k < 4) begin
                    case ($urandom_range(0, 5))
                        0: operand = 32'h7FFF_FFFF;
                        1: operand = 32'h8000_0000;
                        2: operand = 32'h0001_0000;
                        3: operand = 32'hFFFF_0000;
                        4: operand = 32'h0000_0001;
                        default: operand = 32'hFFFF_FFFF;
                    endcase
                end else if (k < 9) begin
                    operand = $urandom_range(0, 32'h80000) - 32'h40000;
                end else begin
                    operand = $urandom;
                end
                do_op(op, row, col, operand);
            end
        end
    endtask

    // result side: random stalls, compare each beat with the oldest prediction
    initial begin : result_check
        t_out got, want;
        int   gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        i_out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            while (!(o_out_valid && i_out_ready)) @(posedge i_clk);
            got = o_out;
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t: unexpected beat, expected none, got %h", $time, got);
            end else begin
                want = pending_results.pop_front();
                if (got.read_value !== want.read_value) begin
                    err_count++;
                    $display("%0t: read_value expected %h got %h",
                             $time, want.read_value, got.read_value);
                end
                if (got.status !== want.status) begin
                    err_count++;
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, got.status);
                end
                if (got.slot_used !== want.slot_used) begin
                    err_count++;
                    $display("%0t: slot_used expected %0d got %0d",
                             $time, want.slot_used, got.slot_used);
                end
            end
            gap = $urandom_range(0, out_max_gap);
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        for (int i = 0; i < MAX_ROWS*MAX_SLOTS; i++) begin
            entry_val[i] = '0;
            entry_occ[i] = 1'b0;
        end
        rows_in_use  = 9'd256;
        cols_in_use  = 9'd256;
        slots_in_use = 4'd8;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_rounding_full_row();
        test_range_and_regs();
        test_random_traffic();
        wait_idle();
        repeat (50) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
